// ===== rtl/jsif_pkg.sv =====
// jsif_pkg: shared types and fixed-point constants of the jog scroll index filter
// used by jsif_mulq, jsif_core and jog_scroll_index_filter_top
package jsif_pkg;

  // fixed-point format and menu size limit
  localparam int FRAC_BITS = 16;
  localparam int MAX_ITEMS = 256;

  // Q.F constants, rounded to nearest
  localparam logic [17:0] K_0P4   = 18'(((2 << FRAC_BITS) + 2) / 5);
  localparam logic [17:0] K_0P05  = 18'(((1 << FRAC_BITS) + 10) / 20);
  localparam logic [31:0] K_0P1   = 32'(((1 << FRAC_BITS) + 5) / 10);
  localparam logic [31:0] K_0P001 = 32'(((1 << FRAC_BITS) + 500) / 1000);
  localparam logic [31:0] Q_ONE   = 32'(1 << FRAC_BITS);
  localparam logic [31:0] Q_HALF  = 32'(1 << (FRAC_BITS - 1));

  // configuration register indexes
  localparam logic [1:0] CFG_ENTRY_COUNT = 2'd0;
  localparam logic [1:0] CFG_BACK_ENTRY  = 2'd1;
  localparam logic [1:0] CFG_DRAG_GAIN   = 2'd2;

  // request operation codes
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // drag gain after reset: 1.0
  localparam logic [17:0] DRAG_RESET = 18'(1 << FRAC_BITS);

  typedef struct packed {
    logic [8:0]  entry_count;
    logic        has_back_entry;
    logic [17:0] drag_gain;
  } jsif_cfg_t;

  typedef struct packed {
    logic signed [8:0]  menu_index;
    logic signed [24:0] position_fixed;
  } jsif_result_t;

endpackage

// ===== rtl/jog_scroll_index_filter_top.sv =====
// jog_scroll_index_filter_top: configuration registers, request handshake and result register
// depends on jsif_pkg and jsif_core (which uses jsif_mulq)
//
// Add requests fold a signed jog count into the force, and the block accepts the next
// request in the following cycle. A tick request runs through its steps from acceptance
// to the next acceptance: one shared multiplier is used in turn for the
// force scaling, the snap pull and the drag gain, followed by the velocity, position and
// clamp steps. in_stall is high while a tick is in flight. Each tick gives one result,
// held in an output register, so a new request is taken while a result waits; a tick
// that finishes while the previous result is still stalled holds in its clamp step.
// An add gives no result. Configuration writes are always ready.
module jog_scroll_index_filter_top import jsif_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic signed [7:0]  jog_delta,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [8:0]  menu_index,
  output logic signed [24:0] position_fixed,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [17:0]        cfg_data
);

  jsif_cfg_t    cfg;
  jsif_result_t result;
  logic         busy;
  logic         res_load;
  logic         res_free;
  logic         start;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign start     = in_valid && !busy;
  assign res_free  = !out_valid || !out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.entry_count    <= 9'd0;
      cfg.has_back_entry <= 1'b0;
      cfg.drag_gain      <= DRAG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ENTRY_COUNT: cfg.entry_count    <= cfg_data[8:0];
        CFG_BACK_ENTRY:  cfg.has_back_entry <= cfg_data[0];
        CFG_DRAG_GAIN:   cfg.drag_gain      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      menu_index     <= result.menu_index;
      position_fixed <= result.position_fixed;
    end
  end

  jsif_core u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .jog_delta (jog_delta),
    .cfg       (cfg),
    .res_free  (res_free),
    .busy      (busy),
    .res_load  (res_load),
    .result    (result)
  );

endmodule

// ===== rtl/jsif_mulq.sv =====
// jsif_mulq: shared signed-by-unsigned Q.F multiplier, rounded half away from zero
// depends on jsif_pkg for FRAC_BITS and Q_HALF
module jsif_mulq import jsif_pkg::*; (
  input  logic signed [31:0] a,
  input  logic        [17:0] b,
  output logic signed [34:0] y
);

  logic [31:0] mag;
  logic [49:0] prod;
  logic [33:0] rnd;

  // magnitude, exact product, round and restore sign
  always_comb begin
    mag  = a[31] ? (~a + 32'd1) : a;
    prod = 50'(mag) * 50'(b);
    rnd  = 34'((prod + 50'(Q_HALF)) >> FRAC_BITS);
    y    = a[31] ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
  end

endmodule

// ===== rtl/jsif_core.sv =====
// jsif_core: sequencer and state registers of the jog scroll index filter
// depends on jsif_pkg and drives one shared jsif_mulq over the tick steps
module jsif_core import jsif_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              operation,
  input  logic signed [7:0] jog_delta,
  input  jsif_cfg_t         cfg,
  input  logic              res_free,
  output logic              busy,
  output logic              res_load,
  output jsif_result_t      result
);

  typedef enum logic [2:0] {
    S_IDLE, S_FORCE, S_PULL, S_DRAG, S_VEL, S_POS, S_CLAMP
  } state_t;

  localparam logic signed [35:0] SAT_MAX = 36'sd2147483647;
  localparam logic signed [35:0] SAT_MIN = -36'sd2147483648;
  // top index keeps any position that still rounds down to it
  localparam int POS_MAX = (2 * MAX_ITEMS - 1) * (1 << (FRAC_BITS - 1)) - 1;
  localparam int POS_MIN = -(3 * (1 << (FRAC_BITS - 1)));

  state_t state;
  logic signed [31:0] force_accum;
  logic signed [31:0] scroll_position;
  logic signed [16:0] pull;
  logic signed [34:0] prod;
  logic signed [31:0] vel;
  logic signed [32:0] pos_sum;
  logic signed [18:0] idx;

  logic signed [31:0] mul_a;
  logic        [17:0] mul_b;
  logic signed [34:0] mul_y;

  logic        [FRAC_BITS-1:0] frac;
  logic signed [FRAC_BITS+1:0] pull_raw;
  logic signed [32:0] jog_q;
  logic signed [31:0] add_sat;
  logic signed [31:0] force_next;
  logic signed [16:0] pull_next;
  logic signed [31:0] vel_sat;
  logic signed [31:0] vel_next;
  logic signed [32:0] pos_next;
  logic        [32:0] pos_mag;
  logic        [33:0] pos_rnd;
  logic signed [18:0] idx_next;
  logic        [8:0]  count;
  logic signed [18:0] top_idx;
  logic signed [18:0] idx_c;
  logic signed [32:0] pos_c;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) r = 32'sh7FFFFFFF;
    else if (v < SAT_MIN) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic below_thr(input logic signed [35:0] v, input logic [31:0] thr);
    logic [35:0] m;
    m = v[35] ? 36'(-v) : 36'(v);
    return m < 36'(thr);
  endfunction

  // shared multiplier
  jsif_mulq u_mulq (
    .a (mul_a),
    .b (mul_b),
    .y (mul_y)
  );

  // snap pull toward the nearer whole position
  always_comb begin
    frac = scroll_position[FRAC_BITS-1:0];
    if ({1'b0, frac} < (FRAC_BITS + 1)'(Q_HALF)) begin
      pull_raw = -$signed({2'b00, frac});
    end else begin
      pull_raw = $signed((FRAC_BITS + 2)'(Q_ONE) - {2'b00, frac});
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    case (state)
      S_FORCE: begin
        mul_a = force_accum;
        mul_b = K_0P4;
      end
      S_PULL: begin
        mul_a = {{(32 - FRAC_BITS - 2){pull_raw[FRAC_BITS+1]}}, pull_raw};
        mul_b = K_0P05;
      end
      default: begin
        mul_a = force_accum;
        mul_b = cfg.drag_gain;
      end
    endcase
  end

  // jog add with saturation
  always_comb begin
    jog_q   = 33'(jog_delta) <<< FRAC_BITS;
    add_sat = sat32(36'(33'(force_accum) + jog_q));
  end

  // dead zones after the force and pull products and after the velocity sum
  always_comb begin
    force_next = below_thr(36'(mul_y), K_0P1) ? 32'sd0 : mul_y[31:0];
    pull_next  = below_thr(36'(mul_y), K_0P001) ? 17'sd0 : mul_y[16:0];
    vel_sat    = sat32(36'(prod) + 36'(pull));
    vel_next   = below_thr(36'(vel_sat), K_0P001) ? 32'sd0 : vel_sat;
  end

  // advance and round half away from zero
  always_comb begin
    pos_next = 33'(scroll_position) + 33'(vel);
    pos_mag  = pos_next[32] ? 33'(-pos_next) : 33'(pos_next);
    pos_rnd  = 34'(pos_mag) + 34'(Q_HALF);
    if (pos_next[32]) begin
      idx_next = -$signed({1'b0, pos_rnd[33:FRAC_BITS]});
    end else begin
      idx_next = $signed({1'b0, pos_rnd[33:FRAC_BITS]});
    end
  end

  // clamp to the menu range
  always_comb begin
    count   = (10'(cfg.entry_count) > 10'(MAX_ITEMS)) ? 9'(MAX_ITEMS) : cfg.entry_count;
    top_idx = $signed({10'd0, count}) - 19'sd1;
    idx_c   = idx;
    pos_c   = pos_sum;
    if (idx >= $signed({10'd0, count})) begin
      idx_c = top_idx;
      pos_c = 33'(top_idx) <<< FRAC_BITS;
    end else if (idx < 19'sd0) begin
      if (cfg.has_back_entry) begin
        if (idx < -19'sd1) begin
          idx_c = -19'sd1;
          pos_c = -$signed({1'b0, Q_ONE});
        end
      end else begin
        idx_c = 19'sd0;
        pos_c = 33'sd0;
      end
    end
  end

  assign busy                  = (state != S_IDLE);
  assign res_load              = (state == S_CLAMP) && res_free;
  assign result.menu_index     = idx_c[8:0];
  assign result.position_fixed = pos_c[24:0];

  // sequencer and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      force_accum     <= 32'sd0;
      scroll_position <= 32'sd0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            if (operation == OP_TICK) begin
              state <= S_FORCE;
            end else begin
              force_accum <= add_sat;
            end
          end
        end
        S_FORCE: begin
          force_accum <= force_next;
          state       <= S_PULL;
        end
        S_PULL: begin
          pull  <= pull_next;
          state <= S_DRAG;
        end
        S_DRAG: begin
          prod  <= mul_y;
          state <= S_VEL;
        end
        S_VEL: begin
          vel   <= vel_next;
          state <= S_POS;
        end
        S_POS: begin
          pos_sum <= pos_next;
          idx     <= idx_next;
          state   <= S_CLAMP;
        end
        S_CLAMP: begin
          if (res_free) begin
            scroll_position <= pos_c[31:0];
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a tick request starts the force step
  a_tick_start: assert property (@(posedge clk) disable iff (rst)
    start && (operation == OP_TICK) |=> (state == S_FORCE))
    else $error("tick request did not start the sequence");

  // scaled force is zero or at least the force threshold
  a_force_dead: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == S_FORCE) |-> (force_accum == 32'sd0) ||
      !below_thr(36'(force_accum), K_0P1))
    else $error("scaled force inside dead zone");

  // velocity is zero or at least the velocity threshold
  a_vel_dead: assert property (@(posedge clk) disable iff (rst)
    (state == S_POS) |-> (vel == 32'sd0) || !below_thr(36'(vel), K_0P001))
    else $error("velocity inside dead zone");

  // stored position stays within the clamp window
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    res_load |=> (scroll_position <= 32'(POS_MAX)) && (scroll_position >= 32'(POS_MIN)))
    else $error("position outside clamp window");

endmodule
